// ----- src/pfcs_pkg.sv -----
// ----------------------------------------------------------------------------
// pfcs_pkg
// Shared types and constants of the parallel flash command sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pfcs_pkg;

	localparam int WAIT_W = 28;
	localparam int STEP_W = 3;

	// command codes of an input beat
	localparam logic [2:0] CMD_READ         = 3'd0;
	localparam logic [2:0] CMD_PROGRAM      = 3'd1;
	localparam logic [2:0] CMD_SECTOR_ERASE = 3'd2;
	localparam logic [2:0] CMD_CHIP_ERASE   = 3'd3;
	localparam logic [2:0] CMD_READ_ID      = 3'd4;
	localparam logic [2:0] CMD_READ_VALUE   = 3'd5;

	// configuration register indexes
	localparam logic [2:0] REG_PROGRAM_WAIT = 3'd0;
	localparam logic [2:0] REG_SECTOR_WAIT  = 3'd1;
	localparam logic [2:0] REG_CHIP_WAIT    = 3'd2;
	localparam logic [2:0] REG_ID_WAIT      = 3'd3;
	localparam logic [2:0] REG_MAX_RETRIES  = 3'd4;

	localparam logic [WAIT_W-1:0] RST_PROGRAM_WAIT = 28'd20000;
	localparam logic [WAIT_W-1:0] RST_SECTOR_WAIT  = 28'd25000000;
	localparam logic [WAIT_W-1:0] RST_CHIP_WAIT    = 28'd100000000;
	localparam logic [WAIT_W-1:0] RST_ID_WAIT      = 28'd150;
	localparam logic [7:0]        RST_MAX_RETRIES  = 8'd16;

	// flash bus constants
	localparam logic [15:0] ADDR_UNLOCK1      = 16'h5555;
	localparam logic [15:0] ADDR_UNLOCK2      = 16'h2AAA;
	localparam logic [7:0]  BYTE_UNLOCK1      = 8'hAA;
	localparam logic [7:0]  BYTE_UNLOCK2      = 8'h55;
	localparam logic [7:0]  BYTE_PROGRAM      = 8'hA0;
	localparam logic [7:0]  BYTE_ERASE_SETUP  = 8'h80;
	localparam logic [7:0]  BYTE_CHIP_ERASE   = 8'h10;
	localparam logic [7:0]  BYTE_SECTOR_ERASE = 8'h30;
	localparam logic [7:0]  BYTE_ID_ENTER     = 8'h90;
	localparam logic [7:0]  BYTE_ID_EXIT      = 8'hF0;
	localparam logic [7:0]  BYTE_ERASED       = 8'hFF;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_READ,
		PH_VERIFY,
		PH_ID
	} phase_t;

	typedef enum logic [2:0] {
		JOB_READ,
		JOB_PROGRAM,
		JOB_SECTOR_ERASE,
		JOB_CHIP_ERASE,
		JOB_ID_ENTER,
		JOB_ID_EXIT,
		JOB_DONE
	} job_kind_t;

	typedef enum logic [1:0] {
		KIND_WRITE,
		KIND_READ,
		KIND_WAIT,
		KIND_DONE
	} beat_kind_t;

	typedef struct packed {
		job_kind_t   kind;
		logic [15:0] addr;
		logic [7:0]  data;
		logic        status;
	} job_t;

	typedef struct packed {
		logic [WAIT_W-1:0] program_wait;
		logic [WAIT_W-1:0] sector_wait;
		logic [WAIT_W-1:0] chip_wait;
		logic [WAIT_W-1:0] id_wait;
		logic [7:0]        max_retries;
	} cfg_t;

	typedef struct packed {
		beat_kind_t        kind;
		logic [15:0]       addr;
		logic [7:0]        data;
		logic              slow;
		logic [WAIT_W-1:0] wait_ns;
		logic              status;
		logic [7:0]        rdata;
		logic              last;
	} beat_t;

endpackage

// ----- src/parallel_flash_command_sequencer.sv -----
// ----------------------------------------------------------------------------
// parallel_flash_command_sequencer
// Host-side JEDEC parallel flash command sequencer: turns commands into
// unlock writes, command bytes, timed waits, read cycles and done reports.
// ----------------------------------------------------------------------------
// channel  signals                          beat
// s_       s_tvalid s_tready s_tdata s_tuser  command or returned read byte
// m_       m_tvalid m_tready m_tdata m_tuser  bus cycle, wait or done report
//          m_tlast
// cfg_     cfg_valid cfg_ready cfg_index      register write
//          cfg_data
//
// An input beat is taken whenever the job queue has room; the back end
// then emits one output beat per cycle while m_tready does not stall it,
// 1 to 8 beats per command, paced by its step counter. Read values and
// commands that cause nothing are dropped on entry. Reset clears phase,
// queue and output; config registers return to their defaults. A stalled
// m_ channel backs up into the queue and then s_tready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module parallel_flash_command_sequencer #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // address[15:0], write_data[23:16], bus_read_value[31:24]
	input  logic [2:0]  s_tuser,   // command[2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // bus_address[15:0], bus_data[23:16], slow_setup[24],
	                               // wait_ns[52:25], status[53], result_data[61:54], zero
	output logic [1:0]  m_tuser,   // kind[1:0]
	output logic        m_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [27:0] cfg_data
);
	import pfcs_pkg::*;

	cfg_t  cfg_q;
	job_t  push_job;
	job_t  head;
	beat_t beat;
	logic  in_accept;
	logic  job_push;
	logic  q_pop;
	logic  q_full;
	logic  q_empty;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.program_wait <= RST_PROGRAM_WAIT;
			cfg_q.sector_wait  <= RST_SECTOR_WAIT;
			cfg_q.chip_wait    <= RST_CHIP_WAIT;
			cfg_q.id_wait      <= RST_ID_WAIT;
			cfg_q.max_retries  <= RST_MAX_RETRIES;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_PROGRAM_WAIT: cfg_q.program_wait <= cfg_data;
				REG_SECTOR_WAIT:  cfg_q.sector_wait  <= cfg_data;
				REG_CHIP_WAIT:    cfg_q.chip_wait    <= cfg_data;
				REG_ID_WAIT:      cfg_q.id_wait      <= cfg_data;
				REG_MAX_RETRIES:  cfg_q.max_retries  <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	assign s_tready  = !q_full;
	assign in_accept = s_tvalid && s_tready;

	pfcs_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (in_accept),
		.cmd         (s_tuser),
		.addr        (s_tdata[15:0]),
		.wdata       (s_tdata[23:16]),
		.rval        (s_tdata[31:24]),
		.max_retries (cfg_q.max_retries),
		.job_push    (job_push),
		.job         (push_job)
	);

	pfcs_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (job_push),
		.push_job (push_job),
		.pop      (q_pop),
		.head     (head),
		.full     (q_full),
		.empty    (q_empty)
	);

	pfcs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.empty     (q_empty),
		.cfg       (cfg_q),
		.pop       (q_pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_beat  (beat)
	);

	assign m_tdata = {2'b00, beat.rdata, beat.status, beat.wait_ns, beat.slow,
		beat.data, beat.addr};
	assign m_tuser = beat.kind;
	assign m_tlast = beat.last;

`ifndef SYNTHESIS
	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (beat.kind == KIND_DONE) |-> m_tlast)
		else $error("done report without last");

	a_slow_is_unlock: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && beat.slow |-> (beat.kind == KIND_WRITE) &&
			(beat.addr == ADDR_UNLOCK1) && (beat.data == BYTE_UNLOCK1))
		else $error("slow setup on a beat other than the first unlock write");

	a_pop_has_job: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("job retired from an empty queue");

	a_last_retires: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> m_tvalid && m_tlast)
		else $error("job retired without its last beat loaded");
`endif

endmodule

// ----- src/pfcs_front.sv -----
// ----------------------------------------------------------------------------
// pfcs_front
// Accepts command beats, tracks the pending read phase and queues at most one job per beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pfcs_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            accept,
	input  logic [2:0]      cmd,
	input  logic [15:0]     addr,
	input  logic [7:0]      wdata,
	input  logic [7:0]      rval,
	input  logic [7:0]      max_retries,
	output logic            job_push,
	output pfcs_pkg::job_t  job
);
	import pfcs_pkg::*;

	phase_t      phase_q, phase_d;
	logic [15:0] held_addr_q, held_addr_d;
	logic [7:0]  held_data_q, held_data_d;
	logic [7:0]  attempts_q, attempts_d;

	logic verify_ok;
	logic retry_ok;

	assign verify_ok = (rval == held_data_q);
	assign retry_ok  = (attempts_q < max_retries);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			held_addr_q <= '0;
			held_data_q <= '0;
			attempts_q  <= '0;
		end else begin
			phase_q     <= phase_d;
			held_addr_q <= held_addr_d;
			held_data_q <= held_data_d;
			attempts_q  <= attempts_d;
		end
	end

	// next state
	always_comb begin
		phase_d     = phase_q;
		held_addr_d = held_addr_q;
		held_data_d = held_data_q;
		attempts_d  = attempts_q;
		if (accept) begin
			if (cmd == CMD_READ_VALUE) begin
				unique case (phase_q)
					PH_READ: begin
						phase_d = PH_IDLE;
					end
					PH_VERIFY: begin
						if (verify_ok) begin
							phase_d = PH_IDLE;
						end else if (retry_ok) begin
							attempts_d = attempts_q + 8'd1;
						end else begin
							phase_d = PH_IDLE;
						end
					end
					PH_ID: begin
						phase_d = PH_IDLE;
					end
					default: begin
					end
				endcase
			end else if (phase_q == PH_IDLE) begin
				unique case (cmd) inside
					CMD_READ: begin
						held_addr_d = addr;
						phase_d     = PH_READ;
					end
					CMD_PROGRAM: begin
						if (wdata != BYTE_ERASED) begin
							held_addr_d = addr;
							held_data_d = wdata;
							attempts_d  = '0;
							phase_d     = PH_VERIFY;
						end
					end
					CMD_READ_ID: begin
						held_addr_d = {8'h00, addr[7:0]};
						phase_d     = PH_ID;
					end
					CMD_SECTOR_ERASE, CMD_CHIP_ERASE: begin
					end
					default: begin
					end
				endcase
			end
		end
	end

	// job for the back end
	always_comb begin
		job_push = 1'b0;
		job      = '0;
		if (accept) begin
			if (cmd == CMD_READ_VALUE) begin
				unique case (phase_q)
					PH_READ: begin
						job_push = 1'b1;
						job.kind = JOB_DONE;
						job.data = rval;
					end
					PH_VERIFY: begin
						job_push = 1'b1;
						if (verify_ok) begin
							job.kind = JOB_DONE;
							job.data = rval;
						end else if (retry_ok) begin
							job.kind = JOB_PROGRAM;
							job.addr = held_addr_q;
							job.data = held_data_q;
						end else begin
							job.kind   = JOB_DONE;
							job.data   = rval;
							job.status = 1'b1;
						end
					end
					PH_ID: begin
						job_push = 1'b1;
						job.kind = JOB_ID_EXIT;
						job.data = rval;
					end
					default: begin
					end
				endcase
			end else if (phase_q == PH_IDLE) begin
				unique case (cmd) inside
					CMD_READ: begin
						job_push = 1'b1;
						job.kind = JOB_READ;
						job.addr = addr;
					end
					CMD_PROGRAM: begin
						job_push = 1'b1;
						if (wdata == BYTE_ERASED) begin
							job.kind = JOB_DONE;
							job.data = BYTE_ERASED;
						end else begin
							job.kind = JOB_PROGRAM;
							job.addr = addr;
							job.data = wdata;
						end
					end
					CMD_SECTOR_ERASE: begin
						job_push = 1'b1;
						job.kind = JOB_SECTOR_ERASE;
						job.addr = addr;
					end
					CMD_CHIP_ERASE: begin
						job_push = 1'b1;
						job.kind = JOB_CHIP_ERASE;
					end
					CMD_READ_ID: begin
						job_push = 1'b1;
						job.kind = JOB_ID_ENTER;
						job.addr = {8'h00, addr[7:0]};
					end
					default: begin
					end
				endcase
			end
		end
	end

endmodule

// ----- src/pfcs_queue.sv -----
// ----------------------------------------------------------------------------
// pfcs_queue
// Small job queue between the front and back ends.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pfcs_queue #(
	parameter int DEPTH = 2
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  pfcs_pkg::job_t  push_job,
	input  logic            pop,
	output pfcs_pkg::job_t  head,
	output logic            full,
	output logic            empty
);
	import pfcs_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	job_t             slots_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	logic do_push;
	logic do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = slots_q[rd_ptr_q];

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] n;
		if (p == PTR_W'(DEPTH - 1)) begin
			n = '0;
		end else begin
			n = p + PTR_W'(1);
		end
		return n;
	endfunction

	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

// ----- src/pfcs_back.sv -----
// ----------------------------------------------------------------------------
// pfcs_back
// Expands the job at the queue head into bus-cycle, wait and done beats, one per cycle while out_ready allows.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pfcs_back (
	input  logic            clk,
	input  logic            arst_n,
	input  pfcs_pkg::job_t  head,
	input  logic            empty,
	input  pfcs_pkg::cfg_t  cfg,
	output logic            pop,
	output logic            out_valid,
	input  logic            out_ready,
	output pfcs_pkg::beat_t out_beat
);
	import pfcs_pkg::*;

	logic [STEP_W-1:0] step_q;
	logic              out_valid_q;
	beat_t             out_beat_q;
	beat_t             beat;
	logic              load;
	logic              is_erase;
	logic [7:0]        cmd_byte;

	assign is_erase = (head.kind == JOB_SECTOR_ERASE) || (head.kind == JOB_CHIP_ERASE);

	always_comb begin
		unique case (head.kind) inside
			JOB_PROGRAM:                       cmd_byte = BYTE_PROGRAM;
			JOB_SECTOR_ERASE, JOB_CHIP_ERASE:  cmd_byte = BYTE_ERASE_SETUP;
			JOB_ID_ENTER:                      cmd_byte = BYTE_ID_ENTER;
			JOB_ID_EXIT:                       cmd_byte = BYTE_ID_EXIT;
			default:                           cmd_byte = '0;
		endcase
	end

	always_comb begin
		beat = '0;
		if (head.kind == JOB_READ) begin
			beat.kind = KIND_READ;
			beat.addr = head.addr;
			beat.last = 1'b1;
		end else if (head.kind == JOB_DONE) begin
			beat.kind   = KIND_DONE;
			beat.status = head.status;
			beat.rdata  = head.data;
			beat.last   = 1'b1;
		end else if (step_q < STEP_W'(3)) begin
			// unlock pair and command byte
			beat.kind = KIND_WRITE;
			case (step_q)
				STEP_W'(0): begin
					beat.addr = ADDR_UNLOCK1;
					beat.data = BYTE_UNLOCK1;
					beat.slow = is_erase;
				end
				STEP_W'(1): begin
					beat.addr = ADDR_UNLOCK2;
					beat.data = BYTE_UNLOCK2;
				end
				default: begin
					beat.addr = ADDR_UNLOCK1;
					beat.data = cmd_byte;
				end
			endcase
		end else begin
			unique case (head.kind) inside
				JOB_PROGRAM: begin
					case (step_q)
						STEP_W'(3): begin
							beat.kind = KIND_WRITE;
							beat.addr = head.addr;
							beat.data = head.data;
						end
						STEP_W'(4): begin
							beat.kind    = KIND_WAIT;
							beat.wait_ns = cfg.program_wait;
						end
						default: begin
							beat.kind = KIND_READ;
							beat.addr = head.addr;
							beat.last = 1'b1;
						end
					endcase
				end
				JOB_SECTOR_ERASE, JOB_CHIP_ERASE: begin
					case (step_q)
						STEP_W'(3): begin
							beat.kind = KIND_WRITE;
							beat.addr = ADDR_UNLOCK1;
							beat.data = BYTE_UNLOCK1;
						end
						STEP_W'(4): begin
							beat.kind = KIND_WRITE;
							beat.addr = ADDR_UNLOCK2;
							beat.data = BYTE_UNLOCK2;
						end
						STEP_W'(5): begin
							beat.kind = KIND_WRITE;
							if (head.kind == JOB_SECTOR_ERASE) begin
								beat.addr = head.addr;
								beat.data = BYTE_SECTOR_ERASE;
							end else begin
								beat.addr = ADDR_UNLOCK1;
								beat.data = BYTE_CHIP_ERASE;
							end
						end
						STEP_W'(6): begin
							beat.kind    = KIND_WAIT;
							beat.wait_ns = (head.kind == JOB_SECTOR_ERASE) ?
								cfg.sector_wait : cfg.chip_wait;
						end
						default: begin
							beat.kind = KIND_DONE;
							beat.last = 1'b1;
						end
					endcase
				end
				JOB_ID_ENTER, JOB_ID_EXIT: begin
					if (step_q == STEP_W'(3)) begin
						beat.kind    = KIND_WAIT;
						beat.wait_ns = cfg.id_wait;
					end else if (head.kind == JOB_ID_ENTER) begin
						beat.kind = KIND_READ;
						beat.addr = head.addr;
						beat.last = 1'b1;
					end else begin
						beat.kind  = KIND_DONE;
						beat.rdata = head.data;
						beat.last  = 1'b1;
					end
				end
				default: begin
					beat.last = 1'b1;
				end
			endcase
		end
	end

	assign load = !out_valid_q || out_ready;
	assign pop  = load && !empty && beat.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			step_q      <= '0;
		end else if (load) begin
			out_valid_q <= !empty;
			if (!empty) begin
				step_q <= beat.last ? '0 : step_q + STEP_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && !empty) begin
			out_beat_q <= beat;
		end
	end

	assign out_valid = out_valid_q;
	assign out_beat  = out_beat_q;

endmodule
